>>> design/mfss_pkg.sv
// shared types and constants for the monochrome framebuffer scaled scanout
`default_nettype none
package mfss_pkg;

   localparam int CANVAS_WIDTH_DEF  = 128;
   localparam int CANVAS_HEIGHT_DEF = 64;
   localparam int SCALE_FACTOR_DEF  = 2;
   localparam int ORIGIN_X_DEF      = 32;
   localparam int ORIGIN_Y_DEF      = 21;

   localparam int STORE_DEPTH = 1024;
   localparam int IDX_W       = 10;

   localparam logic [7:0]  CMD_CASET = 8'h2A;
   localparam logic [7:0]  CMD_RASET = 8'h2B;
   localparam logic [7:0]  CMD_RAMWR = 8'h2C;

   localparam logic [7:0]  COLUMN_OFFSET_RST = 8'd0;
   localparam logic [7:0]  ROW_OFFSET_RST    = 8'd35;
   localparam logic [15:0] INK_COLOR_RST     = 16'h0000;
   localparam logic [15:0] PAPER_COLOR_RST   = 16'hFFFF;

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_FETCH = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      CSR_COLUMN_OFFSET = 2'd0,
      CSR_ROW_OFFSET    = 2'd1,
      CSR_INK_COLOR     = 2'd2,
      CSR_PAPER_COLOR   = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      HDR_CASET   = 4'd0,
      HDR_XS_HI   = 4'd1,
      HDR_XS_LO   = 4'd2,
      HDR_XE_HI   = 4'd3,
      HDR_XE_LO   = 4'd4,
      HDR_RASET   = 4'd5,
      HDR_YS_HI   = 4'd6,
      HDR_YS_LO   = 4'd7,
      HDR_YE_HI   = 4'd8,
      HDR_YE_LO   = 4'd9,
      HDR_RAMWR   = 4'd10
   } header_step_type;

   typedef enum logic [1:0] {
      ST_CLEAR  = 2'd0,
      ST_IDLE   = 2'd1,
      ST_LOOKUP = 2'd2,
      ST_RESP   = 2'd3
   } state_type;

   typedef struct packed {
      logic clear_en;
      logic store_wr;
      logic fetch_rd;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } status_type;

endpackage
`default_nettype wire

>>> design/mfss_req_if.sv
// request channel: canvas writes and stream fetches
`default_nettype none
interface mfss_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [9:0] canvas_address;
   logic [7:0] canvas_byte;

   modport source (output valid, output func, output canvas_address, output canvas_byte,
                   input ready);
   modport sink (input valid, input func, input canvas_address, input canvas_byte,
                 output ready);
endinterface
`default_nettype wire

>>> design/mfss_rsp_if.sv
// response channel: display stream bytes
`default_nettype none
interface mfss_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] spi_byte;
   logic       is_data;
   logic       frame_last;

   modport source (output valid, output spi_byte, output is_data, output frame_last,
                   input ready);
   modport sink (input valid, input spi_byte, input is_data, input frame_last,
                 output ready);
endinterface
`default_nettype wire

>>> design/mfss_csr_if.sv
// configuration write channel
`default_nettype none
interface mfss_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  addr;
   logic [15:0] data;

   modport source (output valid, output addr, output data, input ready);
   modport sink (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

>>> design/mfss_ctrl.sv
// controller state machine for the scanout block
`default_nettype none
module mfss_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_func,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire mfss_pkg::status_type status,
   output mfss_pkg::cmd_type         cmd
);

   mfss_pkg::state_type state_ff;
   mfss_pkg::state_type state_in;
   logic                is_fetch;

   assign is_fetch = (req_func == mfss_pkg::FUNC_FETCH);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfss_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mfss_pkg::ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = mfss_pkg::ST_IDLE;
            end
         end
         mfss_pkg::ST_IDLE: begin
            if (req_valid && is_fetch) begin
               state_in = mfss_pkg::ST_LOOKUP;
            end
         end
         mfss_pkg::ST_LOOKUP: begin
            state_in = mfss_pkg::ST_RESP;
         end
         mfss_pkg::ST_RESP: begin
            if (rsp_ready) begin
               state_in = mfss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mfss_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         mfss_pkg::ST_CLEAR: begin
            cmd.clear_en = 1'b1;
         end
         mfss_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.store_wr = req_valid && !is_fetch;
            cmd.fetch_rd = req_valid && is_fetch;
         end
         mfss_pkg::ST_LOOKUP: begin
            cmd.load_rsp = 1'b1;
         end
         mfss_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> design/mfss_datapath.sv
// canvas memory, scan counters, configuration registers and output register
`default_nettype none
module mfss_datapath #(
   parameter int CANVAS_WIDTH  = mfss_pkg::CANVAS_WIDTH_DEF,
   parameter int CANVAS_HEIGHT = mfss_pkg::CANVAS_HEIGHT_DEF,
   parameter int SCALE_FACTOR  = mfss_pkg::SCALE_FACTOR_DEF,
   parameter int ORIGIN_X      = mfss_pkg::ORIGIN_X_DEF,
   parameter int ORIGIN_Y      = mfss_pkg::ORIGIN_Y_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mfss_pkg::cmd_type    cmd,
   output mfss_pkg::status_type      status,
   input  wire logic [9:0]           req_canvas_address,
   input  wire logic [7:0]           req_canvas_byte,
   input  wire logic                 csr_valid,
   input  wire logic [1:0]           csr_addr,
   input  wire logic [15:0]          csr_data,
   output logic [7:0]                rsp_spi_byte,
   output logic                      rsp_is_data,
   output logic                      rsp_frame_last
);

   localparam int IDX_W     = mfss_pkg::IDX_W;
   localparam int ROW_BYTES = (CANVAS_WIDTH + 7) / 8;
   localparam int CX_W      = $clog2(CANVAS_WIDTH);
   localparam int CY_W      = (CANVAS_HEIGHT > 1) ? $clog2(CANVAS_HEIGHT) : 1;
   localparam int SC_W      = (SCALE_FACTOR > 1) ? $clog2(SCALE_FACTOR) : 1;
   localparam logic [15:0] X0_BASE = 16'(ORIGIN_X);
   localparam logic [15:0] X1_BASE = 16'(ORIGIN_X + CANVAS_WIDTH * SCALE_FACTOR - 1);
   localparam logic [15:0] Y0_BASE = 16'(ORIGIN_Y);
   localparam logic [15:0] Y1_BASE = 16'(ORIGIN_Y + CANVAS_HEIGHT * SCALE_FACTOR - 1);

   logic [7:0]       canvas_mem_ff [mfss_pkg::STORE_DEPTH];
   logic [7:0]       mem_q_ff;
   logic [IDX_W-1:0] clr_addr_ff;

   logic [7:0]  column_offset_ff;
   logic [7:0]  row_offset_ff;
   logic [15:0] ink_color_ff;
   logic [15:0] paper_color_ff;

   logic                      in_pixels_ff, in_pixels_in;
   mfss_pkg::header_step_type header_step_ff, header_step_in;
   logic                      lo_ff, lo_in;
   logic [SC_W-1:0]           xs_ff, xs_in;
   logic [SC_W-1:0]           ys_ff, ys_in;
   logic [CX_W-1:0]           cx_ff, cx_in;
   logic [CY_W-1:0]           cy_ff, cy_in;
   logic [IDX_W-1:0]          row_base_ff, row_base_in;

   logic [7:0]  spi_byte_ff, spi_byte_in;
   logic        is_data_ff, is_data_in;
   logic        frame_last_ff, frame_last_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [7:0]       wr_data;
   logic [IDX_W-1:0] rd_addr;

   logic [15:0] x0, x1, y0, y1;
   logic        pix_bit;
   logic [15:0] pix_color;
   logic        xs_end, ys_end, cx_end, cy_end;

   // memory ports
   assign wr_en   = cmd.clear_en || cmd.store_wr;
   assign wr_addr = cmd.clear_en ? clr_addr_ff : req_canvas_address;
   assign wr_data = cmd.clear_en ? 8'h00 : req_canvas_byte;
   assign rd_addr = row_base_ff + IDX_W'(cx_ff >> 3);

   assign status.clear_last = (clr_addr_ff == IDX_W'(mfss_pkg::STORE_DEPTH - 1));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         canvas_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch_rd) begin
         mem_q_ff <= canvas_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_en) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         column_offset_ff <= mfss_pkg::COLUMN_OFFSET_RST;
         row_offset_ff    <= mfss_pkg::ROW_OFFSET_RST;
         ink_color_ff     <= mfss_pkg::INK_COLOR_RST;
         paper_color_ff   <= mfss_pkg::PAPER_COLOR_RST;
      end else if (csr_valid) begin
         unique case (mfss_pkg::csr_index_type'(csr_addr))
            mfss_pkg::CSR_COLUMN_OFFSET: column_offset_ff <= csr_data[7:0];
            mfss_pkg::CSR_ROW_OFFSET:    row_offset_ff    <= csr_data[7:0];
            mfss_pkg::CSR_INK_COLOR:     ink_color_ff     <= csr_data;
            mfss_pkg::CSR_PAPER_COLOR:   paper_color_ff   <= csr_data;
            default:                     ink_color_ff     <= ink_color_ff;
         endcase
      end
   end

   // window bounds
   assign x0 = X0_BASE + {8'h00, column_offset_ff};
   assign x1 = X1_BASE + {8'h00, column_offset_ff};
   assign y0 = Y0_BASE + {8'h00, row_offset_ff};
   assign y1 = Y1_BASE + {8'h00, row_offset_ff};

   assign pix_bit   = mem_q_ff[3'd7 - cx_ff[2:0]];
   assign pix_color = pix_bit ? ink_color_ff : paper_color_ff;

   assign xs_end = (xs_ff == SC_W'(SCALE_FACTOR - 1));
   assign ys_end = (ys_ff == SC_W'(SCALE_FACTOR - 1));
   assign cx_end = (cx_ff == CX_W'(CANVAS_WIDTH - 1));
   assign cy_end = (cy_ff == CY_W'(CANVAS_HEIGHT - 1));

   always_comb begin
      in_pixels_in   = in_pixels_ff;
      header_step_in = header_step_ff;
      lo_in          = lo_ff;
      xs_in          = xs_ff;
      ys_in          = ys_ff;
      cx_in          = cx_ff;
      cy_in          = cy_ff;
      row_base_in    = row_base_ff;
      spi_byte_in    = spi_byte_ff;
      is_data_in     = is_data_ff;
      frame_last_in  = frame_last_ff;
      if (cmd.load_rsp) begin
         frame_last_in = 1'b0;
         if (!in_pixels_ff) begin
            is_data_in = 1'b1;
            unique case (header_step_ff)
               mfss_pkg::HDR_CASET: begin
                  spi_byte_in = mfss_pkg::CMD_CASET;
                  is_data_in  = 1'b0;
               end
               mfss_pkg::HDR_XS_HI: spi_byte_in = x0[15:8];
               mfss_pkg::HDR_XS_LO: spi_byte_in = x0[7:0];
               mfss_pkg::HDR_XE_HI: spi_byte_in = x1[15:8];
               mfss_pkg::HDR_XE_LO: spi_byte_in = x1[7:0];
               mfss_pkg::HDR_RASET: begin
                  spi_byte_in = mfss_pkg::CMD_RASET;
                  is_data_in  = 1'b0;
               end
               mfss_pkg::HDR_YS_HI: spi_byte_in = y0[15:8];
               mfss_pkg::HDR_YS_LO: spi_byte_in = y0[7:0];
               mfss_pkg::HDR_YE_HI: spi_byte_in = y1[15:8];
               mfss_pkg::HDR_YE_LO: spi_byte_in = y1[7:0];
               default: begin
                  spi_byte_in = mfss_pkg::CMD_RAMWR;
                  is_data_in  = 1'b0;
               end
            endcase
            if (header_step_ff == mfss_pkg::HDR_RAMWR) begin
               header_step_in = mfss_pkg::HDR_CASET;
               in_pixels_in   = 1'b1;
            end else begin
               header_step_in = mfss_pkg::header_step_type'(header_step_ff + 4'd1);
            end
         end else begin
            is_data_in  = 1'b1;
            spi_byte_in = lo_ff ? pix_color[7:0] : pix_color[15:8];
            if (!lo_ff) begin
               lo_in = 1'b1;
            end else begin
               lo_in = 1'b0;
               if (!xs_end) begin
                  xs_in = xs_ff + 1'b1;
               end else begin
                  xs_in = '0;
                  if (!cx_end) begin
                     cx_in = cx_ff + 1'b1;
                  end else begin
                     cx_in = '0;
                     if (!ys_end) begin
                        ys_in = ys_ff + 1'b1;
                     end else begin
                        ys_in = '0;
                        if (!cy_end) begin
                           cy_in       = cy_ff + 1'b1;
                           row_base_in = row_base_ff + IDX_W'(ROW_BYTES);
                        end else begin
                           // end of frame, next fetch starts a new header
                           cy_in          = '0;
                           row_base_in    = '0;
                           in_pixels_in   = 1'b0;
                           header_step_in = mfss_pkg::HDR_CASET;
                           frame_last_in  = 1'b1;
                        end
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_pixels_ff   <= 1'b0;
         header_step_ff <= mfss_pkg::HDR_CASET;
         lo_ff          <= 1'b0;
         xs_ff          <= '0;
         ys_ff          <= '0;
         cx_ff          <= '0;
         cy_ff          <= '0;
         row_base_ff    <= '0;
      end else begin
         in_pixels_ff   <= in_pixels_in;
         header_step_ff <= header_step_in;
         lo_ff          <= lo_in;
         xs_ff          <= xs_in;
         ys_ff          <= ys_in;
         cx_ff          <= cx_in;
         cy_ff          <= cy_in;
         row_base_ff    <= row_base_in;
      end
   end

   always_ff @(posedge clock) begin
      spi_byte_ff   <= spi_byte_in;
      is_data_ff    <= is_data_in;
      frame_last_ff <= frame_last_in;
   end

   assign rsp_spi_byte   = spi_byte_ff;
   assign rsp_is_data    = is_data_ff;
   assign rsp_frame_last = frame_last_ff;

endmodule
`default_nettype wire

>>> design/mono_framebuffer_scaled_scanout.sv
// top level of the monochrome framebuffer scaled scanout
//
// req_ch carries one transaction per canvas write (func 0: canvas_byte stored at
// canvas_address) or per stream fetch (func 1: the other fields are ignored).
// rsp_ch returns one transaction per fetch: the next display stream byte, its
// data/command flag and a flag on the final pixel byte of the frame. A frame is
// the 11-byte window setup followed by the scaled RGB565 pixels, high byte first.
// csr_ch writes column_offset, row_offset, ink_color and paper_color by index.
// csr_ch.ready is always high; writes must go in only while no fetch is in
// flight, which the block itself does not enforce. A write gives no response.
// A fetch reads the canvas into a read register, then ST_LOOKUP loads the
// output register, which shows on rsp_ch in ST_RESP; req_ch.ready stays low
// until that response is taken. The canvas memory has one read and one write
// port, with one read per fetch. If rsp_ch.ready is low the response holds and
// no new request is taken. Reset returns the registers to their defaults and
// the stream to the start of a header, then clears the 1024-byte canvas one
// byte a cycle: req_ch.ready stays low until the clear is done.
`default_nettype none
module mono_framebuffer_scaled_scanout #(
   parameter int CANVAS_WIDTH  = mfss_pkg::CANVAS_WIDTH_DEF,
   parameter int CANVAS_HEIGHT = mfss_pkg::CANVAS_HEIGHT_DEF,
   parameter int SCALE_FACTOR  = mfss_pkg::SCALE_FACTOR_DEF,
   parameter int ORIGIN_X      = mfss_pkg::ORIGIN_X_DEF,
   parameter int ORIGIN_Y      = mfss_pkg::ORIGIN_Y_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   mfss_req_if.sink    req_ch,
   mfss_rsp_if.source  rsp_ch,
   mfss_csr_if.sink    csr_ch
);

   mfss_pkg::cmd_type    cmd;
   mfss_pkg::status_type status;

   assign csr_ch.ready = 1'b1;

   mfss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_ch.func),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mfss_datapath #(
      .CANVAS_WIDTH  (CANVAS_WIDTH),
      .CANVAS_HEIGHT (CANVAS_HEIGHT),
      .SCALE_FACTOR  (SCALE_FACTOR),
      .ORIGIN_X      (ORIGIN_X),
      .ORIGIN_Y      (ORIGIN_Y)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_canvas_address (req_ch.canvas_address),
      .req_canvas_byte    (req_ch.canvas_byte),
      .csr_valid          (csr_ch.valid),
      .csr_addr           (csr_ch.addr),
      .csr_data           (csr_ch.data),
      .rsp_spi_byte       (rsp_ch.spi_byte),
      .rsp_is_data        (rsp_ch.is_data),
      .rsp_frame_last     (rsp_ch.frame_last)
   );

endmodule
`default_nettype wire
